[rtl/core/necd_pkg.sv]
package necd_pkg;

    localparam int DURATION_WIDTH_DEF = 16;
    localparam int DUR_FIELD_W        = 16;
    localparam int TOL_W              = 7;
    localparam int PROD_W             = DUR_FIELD_W + TOL_W;   // expected * percent
    localparam int TOLV_W             = DUR_FIELD_W + 1;       // truncated tolerance
    localparam int WIN_HI_W           = DUR_FIELD_W + 2;       // expected + tolerance

    localparam logic [6:0] FRAME_PULSES = 7'd67;

    localparam logic [15:0]     HEADER_MARK_DEF  = 16'd9000;
    localparam logic [15:0]     HEADER_SPACE_DEF = 16'd4500;
    localparam logic [15:0]     BIT_MARK_DEF     = 16'd562;
    localparam logic [15:0]     ZERO_SPACE_DEF   = 16'd562;
    localparam logic [15:0]     ONE_SPACE_DEF    = 16'd1687;
    localparam logic [TOL_W-1:0] TOLERANCE_DEF   = 7'd30;

    typedef struct packed {
        logic [15:0]      header_mark;
        logic [15:0]      header_space;
        logic [15:0]      bit_mark;
        logic [15:0]      zero_space;
        logic [15:0]      one_space;
        logic [TOL_W-1:0] tolerance;
    } t_cfg;

    typedef struct packed {
        logic [DUR_FIELD_W-1:0] lo;
        logic [WIN_HI_W-1:0]    hi;
    } t_win;

    typedef struct packed {
        t_win header_mark;
        t_win header_space;
        t_win bit_mark;
        t_win zero_space;
        t_win one_space;
    } t_win_set;

    function automatic logic f_in_win(input logic [WIN_HI_W-1:0] dur, input t_win w);
        logic ge_lo;
        logic le_hi;
        ge_lo = dur >= {2'b00, w.lo};
        le_hi = dur <= w.hi;
        return ge_lo && le_hi;
    endfunction

endpackage

[rtl/core/necd_win_calc.sv]
module necd_win_calc (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  necd_pkg::t_cfg       i_cfg,
    output logic                 o_busy,
    output necd_pkg::t_win_set   o_win
);

    localparam logic [2:0] WIN_HDR_MARK   = 3'd0;
    localparam logic [2:0] WIN_HDR_SPACE  = 3'd1;
    localparam logic [2:0] WIN_BIT_MARK   = 3'd2;
    localparam logic [2:0] WIN_ZERO_SPACE = 3'd3;
    localparam logic [2:0] WIN_ONE_SPACE  = 3'd4;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2**23.
    localparam int           RECIP_W     = 25;
    localparam int           RECIP_SHIFT = 31;
    localparam int           MUL_W       = necd_pkg::PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_100 = 25'd21474837;

    logic                              r_iss_on;
    logic [2:0]                        r_iss_idx;
    logic                              r_p1_vld;
    logic [2:0]                        r_p1_idx;
    logic [necd_pkg::DUR_FIELD_W-1:0]  r_p1_exp;
    logic [necd_pkg::PROD_W-1:0]       r_prod;
    logic                              r_p2_vld;
    logic [2:0]                        r_p2_idx;
    logic [necd_pkg::DUR_FIELD_W-1:0]  r_p2_exp;
    logic [necd_pkg::TOLV_W-1:0]       r_tol;
    necd_pkg::t_win_set                r_win;

    logic [necd_pkg::DUR_FIELD_W-1:0]  exp_sel;
    logic [MUL_W-1:0]                  quot_full;
    necd_pkg::t_win                    n_win;

    always_comb begin
        case (r_iss_idx)
            WIN_HDR_MARK:   exp_sel = i_cfg.header_mark;
            WIN_HDR_SPACE:  exp_sel = i_cfg.header_space;
            WIN_BIT_MARK:   exp_sel = i_cfg.bit_mark;
            WIN_ZERO_SPACE: exp_sel = i_cfg.zero_space;
            WIN_ONE_SPACE:  exp_sel = i_cfg.one_space;
            default:        exp_sel = '0;
        endcase
    end

    assign quot_full = {{(MUL_W-necd_pkg::PROD_W){1'b0}}, r_prod}
                     * {{(MUL_W-RECIP_W){1'b0}}, RECIP_100};

    always_comb begin
        // The lower bound stops at zero when the tolerance exceeds the expected value.
        if (r_tol > {1'b0, r_p2_exp}) begin
            n_win.lo = '0;
        end else begin
            n_win.lo = r_p2_exp - r_tol[necd_pkg::DUR_FIELD_W-1:0];
        end
        n_win.hi = {2'b00, r_p2_exp} + {1'b0, r_tol};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_on  <= 1'b1;
            r_iss_idx <= WIN_HDR_MARK;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
        end else begin
            if (i_start) begin
                r_iss_on  <= 1'b1;
                r_iss_idx <= WIN_HDR_MARK;
            end else if (r_iss_on) begin
                r_iss_on  <= (r_iss_idx != WIN_ONE_SPACE);
                r_iss_idx <= r_iss_idx + 3'd1;
            end
            r_p1_vld <= r_iss_on && !i_start;
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_idx <= r_iss_idx;
        r_p1_exp <= exp_sel;
        r_prod   <= {{necd_pkg::TOL_W{1'b0}}, exp_sel}
                  * {{necd_pkg::DUR_FIELD_W{1'b0}}, i_cfg.tolerance};
        r_p2_idx <= r_p1_idx;
        r_p2_exp <= r_p1_exp;
        r_tol    <= quot_full[RECIP_SHIFT +: necd_pkg::TOLV_W];
        if (r_p2_vld) begin
            case (r_p2_idx)
                WIN_HDR_MARK:   r_win.header_mark  <= n_win;
                WIN_HDR_SPACE:  r_win.header_space <= n_win;
                WIN_BIT_MARK:   r_win.bit_mark     <= n_win;
                WIN_ZERO_SPACE: r_win.zero_space   <= n_win;
                WIN_ONE_SPACE:  r_win.one_space    <= n_win;
                default:        r_win              <= r_win;
            endcase
        end
    end

    assign o_busy = r_iss_on || r_p1_vld || r_p2_vld;
    assign o_win  = r_win;

    a_p2_follows_p1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2_vld |-> $past(r_p1_vld))
        else $error("window stage 2 valid without stage 1");

    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iss_on |-> (r_iss_idx <= WIN_ONE_SPACE))
        else $error("window issue index out of range");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> o_busy)
        else $error("window recompute did not start");

endmodule

[rtl/core/nec_ir_frame_decoder_top.sv]
// A pulse beat accepted into the input register moves on to the result register when it fires,
// so a frame result is presented from the result register once its last pulse has fired.
// Throughput: one pulse per cycle outside a window recompute; only a last pulse waits while
// an earlier result is unclaimed. Reset and every register write start a window recompute
// through one shared multiplier pipeline, during which pulses and register writes are held off.
// Reset is synchronous and active low and restores the default timing registers.
module nec_ir_frame_decoder_top #(
    parameter int DURATION_WIDTH = necd_pkg::DURATION_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pulse stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] pulse_duration
    input  logic        i_s_axis_tuser,   // [0] pulse_level
    input  logic        i_s_axis_tlast,   // last_pulse
    // Frame results.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] address, [15:8] command
    output logic        o_m_axis_tuser,   // [0] status
    // Register writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int DUR_W = (DURATION_WIDTH < necd_pkg::DUR_FIELD_W)
                         ? DURATION_WIDTH : necd_pkg::DUR_FIELD_W;

    localparam logic [2:0] REG_HEADER_MARK  = 3'd0;
    localparam logic [2:0] REG_HEADER_SPACE = 3'd1;
    localparam logic [2:0] REG_BIT_MARK     = 3'd2;
    localparam logic [2:0] REG_ZERO_SPACE   = 3'd3;
    localparam logic [2:0] REG_ONE_SPACE    = 3'd4;
    localparam logic [2:0] REG_TOLERANCE    = 3'd5;

    necd_pkg::t_cfg      r_cfg;
    necd_pkg::t_win_set  win;
    logic                win_busy;
    logic                cfg_fire;

    logic                r_a_vld;
    logic [DUR_W-1:0]    r_a_dur;
    logic                r_a_level;
    logic                r_a_last;

    logic [6:0]          r_pos;
    logic [31:0]         r_bits;
    logic                r_failed;

    logic                r_out_vld;
    logic                r_out_status;
    logic [7:0]          r_out_addr;
    logic [7:0]          r_out_cmd;

    logic                adv;
    logic                fire;
    logic [necd_pkg::WIN_HI_W-1:0] dur_ext;
    logic                in_frame;
    logic                ok;
    logic                set_bit;
    logic [6:0]          pos_m3;
    logic [4:0]          bit_idx;
    logic [6:0]          n_pos;
    logic [31:0]         n_bits;
    logic                n_failed;
    logic                good;

    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = !win_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_mark  <= necd_pkg::HEADER_MARK_DEF;
            r_cfg.header_space <= necd_pkg::HEADER_SPACE_DEF;
            r_cfg.bit_mark     <= necd_pkg::BIT_MARK_DEF;
            r_cfg.zero_space   <= necd_pkg::ZERO_SPACE_DEF;
            r_cfg.one_space    <= necd_pkg::ONE_SPACE_DEF;
            r_cfg.tolerance    <= necd_pkg::TOLERANCE_DEF;
        end else if (cfg_fire) begin
            case (i_cfg_index)
                REG_HEADER_MARK:  r_cfg.header_mark  <= i_cfg_data;
                REG_HEADER_SPACE: r_cfg.header_space <= i_cfg_data;
                REG_BIT_MARK:     r_cfg.bit_mark     <= i_cfg_data;
                REG_ZERO_SPACE:   r_cfg.zero_space   <= i_cfg_data;
                REG_ONE_SPACE:    r_cfg.one_space    <= i_cfg_data;
                REG_TOLERANCE:    r_cfg.tolerance    <= i_cfg_data[necd_pkg::TOL_W-1:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    necd_win_calc u_win_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cfg_fire),
        .i_cfg   (r_cfg),
        .o_busy  (win_busy),
        .o_win   (win)
    );

    // Only a last pulse needs the result register; other pulses move on while it is full.
    assign adv             = !r_out_vld || i_m_axis_tready;
    assign fire            = r_a_vld && (adv || !r_a_last);
    assign o_s_axis_tready = !win_busy && (!r_a_vld || fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_a_vld <= i_s_axis_tvalid;
        end else if (fire) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_a_dur   <= i_s_axis_tdata[DUR_W-1:0];
            r_a_level <= i_s_axis_tuser;
            r_a_last  <= i_s_axis_tlast;
        end
    end

    assign dur_ext  = {{(necd_pkg::WIN_HI_W-DUR_W){1'b0}}, r_a_dur};
    assign in_frame = r_pos < necd_pkg::FRAME_PULSES;
    assign pos_m3   = r_pos - 7'd3;
    assign bit_idx  = pos_m3[5:1];

    always_comb begin
        set_bit = 1'b0;
        if (r_pos == 7'd0) begin
            ok = r_a_level && necd_pkg::f_in_win(dur_ext, win.header_mark);
        end else if (r_pos == 7'd1) begin
            ok = !r_a_level && necd_pkg::f_in_win(dur_ext, win.header_space);
        end else if (!r_pos[0]) begin
            ok = r_a_level && necd_pkg::f_in_win(dur_ext, win.bit_mark);
        end else begin
            // A space that fits the one window counts as a one even if it also fits zero.
            set_bit = !r_a_level && necd_pkg::f_in_win(dur_ext, win.one_space);
            ok      = !r_a_level && (set_bit || necd_pkg::f_in_win(dur_ext, win.zero_space));
        end
    end

    assign n_pos    = in_frame ? r_pos + 7'd1 : r_pos;
    assign n_bits   = (in_frame && set_bit) ? (r_bits | (32'd1 << bit_idx)) : r_bits;
    assign n_failed = r_failed || (in_frame && !ok);
    assign good     = (n_pos >= necd_pkg::FRAME_PULSES) && !n_failed
                   && (n_bits[7:0] == ~n_bits[15:8]) && (n_bits[23:16] == ~n_bits[31:24]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_bits   <= '0;
            r_failed <= 1'b0;
        end else if (fire) begin
            if (r_a_last) begin
                r_pos    <= '0;
                r_bits   <= '0;
                r_failed <= 1'b0;
            end else begin
                r_pos    <= n_pos;
                r_bits   <= n_bits;
                r_failed <= n_failed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= fire && r_a_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_a_last) begin
            r_out_status <= !good;
            r_out_addr   <= good ? n_bits[7:0]   : 8'd0;
            r_out_cmd    <= good ? n_bits[23:16] : 8'd0;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_out_cmd, r_out_addr};
    assign o_m_axis_tuser  = r_out_status;

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        win_busy |-> !o_s_axis_tready)
        else $error("pulse accepted during window recompute");

    a_fail_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == 16'd0))
        else $error("failed frame carries nonzero address or command");

    a_pos_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= necd_pkg::FRAME_PULSES)
        else $error("pulse position beyond frame length");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_a_last) |=> (r_pos == 7'd0 && r_bits == 32'd0 && !r_failed))
        else $error("frame state not cleared after last pulse");

endmodule

[verif/nec_ir_tb_pkg.sv]
`timescale 1ns / 1ps
package nec_ir_tb_pkg;

    typedef enum logic [2:0] {
        REG_HEADER_MARK  = 3'd0,
        REG_HEADER_SPACE = 3'd1,
        REG_BIT_MARK     = 3'd2,
        REG_ZERO_SPACE   = 3'd3,
        REG_ONE_SPACE    = 3'd4,
        REG_TOLERANCE    = 3'd5
    } nec_reg_e;

    localparam logic LEVEL_SPACE     = 1'b0;
    localparam logic LEVEL_MARK      = 1'b1;
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_FRAME = 1'b1;

    localparam int PERCENT_SCALE = 100;

endpackage

[verif/nec_frame_checker.sv]
`timescale 1ns / 1ps
module nec_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] pulse_duration
    input  logic        i_s_axis_tuser,   // [0] pulse_level
    input  logic        i_s_axis_tlast,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [15:0] i_m_axis_tdata,   // [7:0] address, [15:8] command
    input  logic        i_m_axis_tuser,   // [0] status
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_mismatch_count,
    output int          o_pending_count
);
    import necd_pkg::*;
    import nec_ir_tb_pkg::*;

    typedef struct packed {
        logic       status;
        logic [7:0] address;
        logic [7:0] command;
    } frame_result_t;

    t_cfg          timing;
    logic [6:0]    pulse_pos;
    logic [31:0]   data_bits;
    logic          frame_bad;
    frame_result_t expected_frames[$];
    int            mismatches = 0;

    function automatic logic within_tolerance(input logic [15:0] dur,
                                              input logic [15:0] nominal,
                                              input logic [6:0]  pct);
        int unsigned margin;
        int unsigned lo;
        int unsigned hi;
        margin = 32'(nominal) * 32'(pct) / PERCENT_SCALE;
        // A tolerance above 100 percent pins the lower bound at zero.
        lo = (margin > nominal) ? 0 : 32'(nominal) - margin;
        hi = 32'(nominal) + margin;
        return (dur >= lo) && (dur <= hi);
    endfunction

    task automatic decode_pulse(input logic [15:0] dur, input logic lvl, input logic lst);
        logic          ok;
        logic [4:0]    bit_idx;
        frame_result_t res;
        // Pulses past the stop mark are neither checked nor counted.
        if (pulse_pos < FRAME_PULSES) begin
            if (pulse_pos == 7'd0) begin
                ok = (lvl == LEVEL_MARK) &&
                     within_tolerance(dur, timing.header_mark, timing.tolerance);
            end else if (pulse_pos == 7'd1) begin
                ok = (lvl == LEVEL_SPACE) &&
                     within_tolerance(dur, timing.header_space, timing.tolerance);
            end else if (!pulse_pos[0]) begin
                ok = (lvl == LEVEL_MARK) &&
                     within_tolerance(dur, timing.bit_mark, timing.tolerance);
            end else begin
                bit_idx = 5'((pulse_pos - 7'd3) >> 1);
                ok = (lvl == LEVEL_SPACE);
                // The one window takes precedence where the two windows overlap.
                if (ok) begin
                    if (within_tolerance(dur, timing.one_space, timing.tolerance)) begin
                        data_bits[bit_idx] = 1'b1;
                    end else if (!within_tolerance(dur, timing.zero_space, timing.tolerance)) begin
                        ok = 1'b0;
                    end
                end
            end
            if (!ok) begin
                frame_bad = 1'b1;
            end
            pulse_pos = pulse_pos + 7'd1;
        end
        if (lst) begin
            if (pulse_pos >= FRAME_PULSES && !frame_bad &&
                data_bits[7:0] == ~data_bits[15:8] &&
                data_bits[23:16] == ~data_bits[31:24]) begin
                res = '{STATUS_OK, data_bits[7:0], data_bits[23:16]};
            end else begin
                res = '{STATUS_NO_FRAME, 8'd0, 8'd0};
            end
            expected_frames.push_back(res);
            pulse_pos = '0;
            data_bits = '0;
            frame_bad = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        frame_result_t got;
        frame_result_t want;
        if (!i_rst_n) begin
            timing = '{HEADER_MARK_DEF, HEADER_SPACE_DEF, BIT_MARK_DEF,
                       ZERO_SPACE_DEF, ONE_SPACE_DEF, TOLERANCE_DEF};
            pulse_pos = '0;
            data_bits = '0;
            frame_bad = 1'b0;
            expected_frames.delete();
        end else begin
            // A result never belongs to a pulse taken at the same edge, so order is free here.
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = '{i_m_axis_tuser, i_m_axis_tdata[7:0], i_m_axis_tdata[15:8]};
                if (expected_frames.size() == 0) begin
                    $display("%0t: unexpected frame result: status %0d address %02h command %02h",
                             $time, got.status, got.address, got.command);
                    mismatches++;
                end else begin
                    want = expected_frames.pop_front();
                    if (got !== want) begin
                        $display("%0t: frame result mismatch: expected status %0d address %02h command %02h, got status %0d address %02h command %02h",
                                 $time, want.status, want.address, want.command,
                                 got.status, got.address, got.command);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_HEADER_MARK:  timing.header_mark  = i_cfg_data;
                    REG_HEADER_SPACE: timing.header_space = i_cfg_data;
                    REG_BIT_MARK:     timing.bit_mark     = i_cfg_data;
                    REG_ZERO_SPACE:   timing.zero_space   = i_cfg_data;
                    REG_ONE_SPACE:    timing.one_space    = i_cfg_data;
                    REG_TOLERANCE:    timing.tolerance    = i_cfg_data[TOL_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                decode_pulse(i_s_axis_tdata, i_s_axis_tuser, i_s_axis_tlast);
            end
        end
        o_pending_count = expected_frames.size();
        o_mismatch_count = mismatches;
    end

endmodule

[verif/nec_ir_frame_decoder_top_tb.sv]
`timescale 1ns / 1ps
module nec_ir_frame_decoder_top_tb;
    import necd_pkg::*;
    import nec_ir_tb_pkg::*;

    localparam int RANDOM_PULSES_PER_PHASE = 260;
    localparam int DRAIN_CYCLES            = 4;
    localparam int NUM_PHASES              = 5;
    localparam int IDLE_GUARD              = 20000;

    typedef enum int {
        CAP_CLEAN,
        CAP_INVERT_BAD,
        CAP_CORRUPT,
        CAP_SHORT,
        CAP_EXTRA,
        CAP_NOISE
    } t_capture_kind;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    int   mismatch_count;
    int   pending_count;
    int   send_idle_pct = 37;
    int   recv_idle_pct = 46;
    int   pulses_sent   = 0;
    t_cfg cur_cfg;
    t_cfg phase_cfg [NUM_PHASES];

    nec_ir_frame_decoder_top DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    nec_frame_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_s_axis_tvalid  (s_tvalid),
        .i_s_axis_tready  (s_tready),
        .i_s_axis_tdata   (s_tdata),
        .i_s_axis_tuser   (s_tuser),
        .i_s_axis_tlast   (s_tlast),
        .i_m_axis_tvalid  (m_tvalid),
        .i_m_axis_tready  (m_tready),
        .i_m_axis_tdata   (m_tdata),
        .i_m_axis_tuser   (m_tuser),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Window bounds under the current timing, clipped to the duration field.
    function automatic void window_bounds(input logic [15:0] nominal, output int lo,
                                          output int hi);
        int margin;
        margin = int'(nominal) * int'(cur_cfg.tolerance) / PERCENT_SCALE;
        lo = (margin > int'(nominal)) ? 0 : int'(nominal) - margin;
        hi = (int'(nominal) + margin > 65535) ? 65535 : int'(nominal) + margin;
    endfunction

    function automatic logic [15:0] pick_in(input logic [15:0] nominal);
        int lo;
        int hi;
        window_bounds(nominal, lo, hi);
        case ($urandom_range(7))
            0:       return 16'(lo);
            1:       return 16'(hi);
            default: return 16'($urandom_range(hi, lo));
        endcase
    endfunction

    // Prefer the part of the zero window that the one window does not cover.
    function automatic logic [15:0] pick_zero_space();
        int zlo;
        int zhi;
        int olo;
        int ohi;
        window_bounds(cur_cfg.zero_space, zlo, zhi);
        window_bounds(cur_cfg.one_space, olo, ohi);
        if (zlo < olo) begin
            return 16'($urandom_range(zlo, (zhi < olo) ? zhi : olo - 1));
        end
        if (zhi > ohi) begin
            return 16'($urandom_range((zlo > ohi) ? zlo : ohi + 1, zhi));
        end
        return 16'($urandom_range(zhi, zlo));
    endfunction

    function automatic logic [15:0] random_duration();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_capture_kind pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 50) return CAP_CLEAN;
        if (r < 60) return CAP_INVERT_BAD;
        if (r < 72) return CAP_CORRUPT;
        if (r < 80) return CAP_SHORT;
        if (r < 88) return CAP_EXTRA;
        return CAP_NOISE;
    endfunction

    // The valid stays high across back-to-back beats; it drops only for a gap.
    task automatic send_pulse(input logic [15:0] dur, input logic lvl, input logic lst);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= dur;
        s_tuser  <= lvl;
        s_tlast  <= lst;
        do @(posedge clk); while (!s_tready);
        pulses_sent++;
    endtask

    task automatic send_noise(input int count);
        for (int k = 1; k <= count; k++) begin
            send_pulse(random_duration(), 1'($urandom_range(1)), k == count);
        end
    endtask

    task automatic send_capture(input t_capture_kind kind);
        logic [7:0]  addr;
        logic [7:0]  cmd;
        logic [31:0] payload;
        int          stop_at;
        int          corrupt_at;
        int          extra;
        logic [15:0] dur;
        logic        lvl;
        if (kind == CAP_NOISE) begin
            send_noise($urandom_range(12, 1));
        end else begin
            addr = 8'($urandom);
            cmd  = 8'($urandom);
            payload = {~cmd, cmd, ~addr, addr};
            if (kind == CAP_INVERT_BAD) begin
                payload[$urandom_range(31)] ^= 1'b1;
            end
            stop_at    = (kind == CAP_SHORT) ? $urandom_range(int'(FRAME_PULSES) - 2, 0)
                                             : int'(FRAME_PULSES) - 1;
            corrupt_at = (kind == CAP_CORRUPT) ? $urandom_range(int'(FRAME_PULSES) - 1, 0) : -1;
            extra      = (kind == CAP_EXTRA) ? $urandom_range(5, 1) : 0;
            for (int k = 0; k <= stop_at; k++) begin
                if (k == 0) begin
                    lvl = LEVEL_MARK;
                    dur = pick_in(cur_cfg.header_mark);
                end else if (k == 1) begin
                    lvl = LEVEL_SPACE;
                    dur = pick_in(cur_cfg.header_space);
                end else if (k % 2 == 0) begin
                    lvl = LEVEL_MARK;
                    dur = pick_in(cur_cfg.bit_mark);
                end else begin
                    lvl = LEVEL_SPACE;
                    dur = payload[(k - 3) / 2] ? pick_in(cur_cfg.one_space) : pick_zero_space();
                end
                if (k == corrupt_at) begin
                    if ($urandom_range(1)) begin
                        lvl = ~lvl;
                    end else begin
                        dur = random_duration();
                    end
                end
                send_pulse(dur, lvl, (k == stop_at) && (extra == 0));
            end
            if (extra > 0) begin
                send_noise(extra);
            end
        end
    endtask

    // Drop the pulse valid and let every outstanding result drain.
    task automatic wait_idle();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        do begin
            @(posedge clk);
            guard++;
        end while (pending_count != 0 && guard < IDLE_GUARD);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input nec_reg_e idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_timing(input t_cfg c);
        write_reg(REG_HEADER_MARK, c.header_mark);
        write_reg(REG_HEADER_SPACE, c.header_space);
        write_reg(REG_BIT_MARK, c.bit_mark);
        write_reg(REG_ZERO_SPACE, c.zero_space);
        write_reg(REG_ONE_SPACE, c.one_space);
        // Bits above the tolerance field are junk and must be dropped.
        write_reg(REG_TOLERANCE, {9'($urandom), c.tolerance});
        cfg_valid <= 1'b0;
        cur_cfg = c;
    endtask

    initial begin
        int start;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cur_cfg = '{HEADER_MARK_DEF, HEADER_SPACE_DEF, BIT_MARK_DEF,
                    ZERO_SPACE_DEF, ONE_SPACE_DEF, TOLERANCE_DEF};
        phase_cfg[0] = cur_cfg;
        phase_cfg[1] = '{16'd65535, 16'd65535, 16'd1, 16'd1, 16'd3, 7'd0};
        phase_cfg[2] = '{16'd1, 16'd65535, 16'd1, 16'd30000, 16'd100, 7'd127};
        phase_cfg[3] = '{16'd12345, 16'd6000, 16'd300, 16'd40000, 16'd1000, 7'd100};
        phase_cfg[4] = '{16'd9000, 16'd4500, 16'd562, 16'd900, 16'd1500, 7'd50};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 2) begin
                send_idle_pct = 37;
                recv_idle_pct = 46;
            end else if (ph < 4) begin
                send_idle_pct = 46;
                recv_idle_pct = 37;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 0) begin
                // Single-pulse captures at the duration extremes.
                send_pulse(16'd0, LEVEL_SPACE, 1'b1);
                send_pulse(16'd65535, LEVEL_MARK, 1'b1);
                // Header space arriving with the carrier on.
                send_pulse(16'd9000, LEVEL_MARK, 1'b0);
                send_pulse(16'd4500, LEVEL_MARK, 1'b1);
                // Window edges at the default timing, cut short after two bits.
                send_pulse(16'd11700, LEVEL_MARK, 1'b0);
                send_pulse(16'd3150, LEVEL_SPACE, 1'b0);
                send_pulse(16'd730, LEVEL_MARK, 1'b0);
                send_pulse(16'd1181, LEVEL_SPACE, 1'b0);
                send_pulse(16'd394, LEVEL_MARK, 1'b0);
                send_pulse(16'd730, LEVEL_SPACE, 1'b1);
                // Just outside the header mark window on either side.
                send_pulse(16'd6299, LEVEL_MARK, 1'b1);
                send_pulse(16'd11701, LEVEL_MARK, 1'b1);
                // A space beyond the one window.
                send_pulse(16'd9000, LEVEL_MARK, 1'b0);
                send_pulse(16'd4500, LEVEL_SPACE, 1'b0);
                send_pulse(16'd562, LEVEL_MARK, 1'b0);
                send_pulse(16'd2194, LEVEL_SPACE, 1'b1);
            end else begin
                wait_idle();
                apply_timing(phase_cfg[ph]);
            end
            start = pulses_sent;
            while (pulses_sent - start < RANDOM_PULSES_PER_PHASE) begin
                send_capture(pick_kind());
            end
        end

        wait_idle();
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/necd_pkg.sv
rtl/core/necd_win_calc.sv
rtl/core/nec_ir_frame_decoder_top.sv
verif/nec_ir_tb_pkg.sv
verif/nec_frame_checker.sv
verif/nec_ir_frame_decoder_top_tb.sv
